// ===== rtl/ufbd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ufbd_pkg;

  // Register indexes on the configuration port.
  localparam logic CFG_IDX_W = 1'b1;
  localparam logic [0:0] REG_CLOCK_HZ     = 1'b0;
  localparam logic [0:0] REG_DOUBLE_SPEED = 1'b1;

  // Field and register widths.
  localparam int unsigned RATE_W  = 32;
  localparam int unsigned CLOCK_W = 32;
  localparam int unsigned DIV_W   = 12;
  localparam int unsigned EXP_W   = 4;
  localparam int unsigned LIMIT_W = 22;
  localparam int unsigned OUT_W   = 24;

  // Reset value of the clock frequency register.
  localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = 32'd32000000;

  // Starting limit of the exponent search (0xfff >> 4).
  localparam logic [LIMIT_W-1:0] LIMIT_START = 22'd255;

  // Exponent bounds, two's complement.
  localparam logic [EXP_W-1:0] EXP_MIN = 4'b1001;
  localparam logic [EXP_W-1:0] EXP_MAX = 4'b0111;

endpackage

`default_nettype wire

// ===== rtl/uart_fractional_baud_divisor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Word contents (lowest bit first)
// in_       in   in_tvalid/in_tready    baud_rate[31:0]
// out_      out  out_tvalid/out_tready  accepted, divisor[11:0], scale_exp[3:0], 7'b0
// cfg_      in   cfg_wr_en              cfg_addr selects clock_hz or double_speed
//
// An accepted rate passes two range compares, a restoring divide for the
// clock-to-rate ratio, an exponent search of up to 15 steps, a prepare and a
// load step and a second divide. A rejected rate goes from the failing compare
// straight to the output. The compares, divide steps, exponent search and
// prepare step share one 34-bit subtractor. Reset (rst_n, synchronous) empties
// the sequencer and the output register. A stalled output word holds, and the
// next rate is taken once the sequencer is back in idle.

module uart_fractional_baud_divisor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // baud_rate[31:0]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,
  // accepted[0], divisor[12:1], scale_exp[16:13], zero[23:17]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHK_HI = 3'd1;
  localparam logic [2:0] S_CHK_LO = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_SRCH   = 3'd4;
  localparam logic [2:0] S_PREP   = 3'd5;
  localparam logic [2:0] S_LOAD   = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  logic [2:0]  state_r, state_nxt;
  logic [31:0] clock_hz_r;
  logic        dbl_r;
  logic [31:0] rate_r, rate_nxt;
  logic [31:0] num_r, num_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] den_r, den_nxt;
  logic [ufbd_pkg::LIMIT_W-1:0] limit_r, limit_nxt;
  logic [3:0]  exp_r, exp_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        pass_r, pass_nxt;
  logic        rej_r, rej_nxt;
  logic        out_vld_r;
  logic [23:0] out_data_r;

  logic [32:0] sub_a, sub_b;
  logic [33:0] sub_d;
  logic        borrow;
  logic [31:0] hi_bound, lo_bound;
  logic [32:0] trial;
  logic        exp_neg, exp_le_m3, exp_lt_m3;
  logic [3:0]  up_sh, dn_sh;
  logic        out_load;
  logic [11:0] div_field;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= ufbd_pkg::CLOCK_HZ_RESET;
      dbl_r      <= 1'b0;
    end else if (cfg_wr_en) begin
      if (cfg_addr == ufbd_pkg::REG_CLOCK_HZ) begin
        clock_hz_r <= cfg_wdata;
      end else if (cfg_addr == ufbd_pkg::REG_DOUBLE_SPEED) begin
        dbl_r <= cfg_wdata[0];
      end
    end
  end

  // Range bounds: clock/8 and clock/2^22, both halved in normal speed.
  assign hi_bound = dbl_r ? {3'b0, clock_hz_r[31:3]}  : {4'b0, clock_hz_r[31:4]};
  assign lo_bound = dbl_r ? {22'b0, clock_hz_r[31:22]} : {23'b0, clock_hz_r[31:23]};

  // Exponent decodes.
  assign exp_neg   = exp_r[3];
  assign exp_le_m3 = exp_r[3] && (exp_r[2:0] <= 3'b101);
  assign exp_lt_m3 = exp_r[3] && (exp_r[2:0] <  3'b101);
  assign up_sh     = exp_r + 4'd3;
  assign dn_sh     = (~exp_r) - 4'd2;

  assign trial = {rem_r, num_r[31]};

  // The shared subtractor; its operands depend on the step.
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state_r)
      S_CHK_HI: begin
        sub_a = {1'b0, hi_bound};
        sub_b = {1'b0, rate_r};
      end
      S_CHK_LO: begin
        sub_a = {1'b0, rate_r};
        sub_b = {1'b0, lo_bound};
      end
      S_DIV: begin
        sub_a = trial;
        sub_b = {1'b0, den_r};
      end
      S_SRCH: begin
        sub_a = {1'b0, num_r};
        sub_b = {11'b0, limit_r};
      end
      S_PREP: begin
        sub_a = {1'b0, clock_hz_r};
        sub_b = {1'b0, rate_r[28:0], 3'b000};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_d  = {1'b0, sub_a} - {1'b0, sub_b};
  assign borrow = sub_d[33];

  // The output register is free when empty or being taken.
  assign out_load = (state_r == S_FIN) && (!out_vld_r || out_tready);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    rate_nxt  = rate_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    limit_nxt = limit_r;
    exp_nxt   = exp_r;
    cnt_nxt   = cnt_r;
    pass_nxt  = pass_r;
    rej_nxt   = rej_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          rate_nxt  = in_tdata;
          rej_nxt   = 1'b0;
          state_nxt = S_CHK_HI;
        end
      end
      S_CHK_HI: begin
        if (borrow || (rate_r == 32'd0)) begin
          rej_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CHK_LO;
        end
      end
      S_CHK_LO: begin
        if (borrow) begin
          rej_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else begin
          // Normal speed works on twice the rate from here on.
          rate_nxt  = dbl_r ? rate_r : {rate_r[30:0], 1'b0};
          den_nxt   = dbl_r ? rate_r : {rate_r[30:0], 1'b0};
          num_nxt   = clock_hz_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          pass_nxt  = 1'b0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // One restoring step: quotient bits shift into the dividend register.
        rem_nxt = borrow ? trial[31:0] : sub_d[31:0];
        num_nxt = {num_r[30:0], ~borrow};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          if (pass_r) begin
            state_nxt = S_FIN;
          end else begin
            limit_nxt = ufbd_pkg::LIMIT_START;
            exp_nxt   = ufbd_pkg::EXP_MIN;
            state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        // Stop at the first exponent whose limit exceeds the ratio, or at the highest.
        if ((exp_r == ufbd_pkg::EXP_MAX) || borrow) begin
          state_nxt = S_PREP;
        end else begin
          limit_nxt = {limit_r[ufbd_pkg::LIMIT_W-2:0], exp_lt_m3};
          exp_nxt   = exp_r + 4'd1;
        end
      end
      S_PREP: begin
        // Numerator base and denominator for the divisor formula.
        rem_nxt   = exp_neg ? sub_d[31:0] : clock_hz_r;
        den_nxt   = exp_le_m3 ? rate_r : (rate_r << up_sh);
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        // Add half the denominator for rounding.
        num_nxt   = (exp_le_m3 ? (rem_r << dn_sh) : rem_r) + {1'b0, den_r[31:1]};
        rem_nxt   = '0;
        cnt_nxt   = '0;
        pass_nxt  = 1'b1;
        state_nxt = S_DIV;
      end
      S_FIN: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rate_r  <= rate_nxt;
    num_r   <= num_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    limit_r <= limit_nxt;
    exp_r   <= exp_nxt;
    cnt_r   <= cnt_nxt;
    pass_r  <= pass_nxt;
    rej_r   <= rej_nxt;
  end

  // Non-negative exponents subtract one from the quotient.
  assign div_field = exp_neg ? num_r[11:0] : (num_r[11:0] - 12'd1);

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (rej_r) begin
        out_data_r <= '0;
      end else begin
        out_data_r <= {7'b0, exp_r, div_field, 1'b1};
      end
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  // A rejected rate carries zero divisor and exponent.
  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[0] |-> out_tdata[23:1] == 23'd0)
    else $error("rejected word has nonzero fields");

  // The exponent never leaves -7..7.
  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[16:13] != 4'b1000)
    else $error("scale exponent out of range");

  // An accepted rate starts with the upper range check.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_CHK_HI)
    else $error("sequencer did not start on an accepted rate");

  // A divide runs exactly 32 steps.
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && cnt_r == 5'd31 |=> state_r == S_SRCH || state_r == S_FIN)
    else $error("divide did not end after 32 steps");
`endif

endmodule

`default_nettype wire

// ===== dv/tb_uart_fractional_baud_divisor.sv =====
`timescale 1ns / 1ps

module tb_uart_fractional_baud_divisor;

  localparam logic [31:0] MIN_RATE_DIV = 32'd4194304;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned IDLE_PCT     = 23;
  localparam int unsigned DRAIN_CYCLES = 100;

  // One result word, packed the way out_tdata carries it (accepted in bit 0).
  typedef struct packed {
    logic signed [ufbd_pkg::EXP_W-1:0] scale_exp;
    logic [ufbd_pkg::DIV_W-1:0]        divisor;
    logic                              accepted;
  } baud_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // baud_rate[31:0]
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  // accepted[0], divisor[12:1], scale_exp[16:13], zero[23:17]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        cfg_wr_en = 1'b0;
  logic [0:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  // Shadow copy of the divisor settings.
  logic [ufbd_pkg::CLOCK_W-1:0] clock_hz_q = ufbd_pkg::CLOCK_HZ_RESET;
  logic                         double_speed_q = 1'b0;

  baud_word_t pending_baud_words[$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned words_checked = 0;
  int unsigned words_accepted = 0;
  int unsigned settings_used = 1;
  logic [15:0] exps_seen = '0;
  logic        no_idle = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;

  uart_fractional_baud_divisor dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A divider that returns all ones for a zero denominator.
  function automatic logic [31:0] divide_or_ones(input logic [31:0] num,
                                                 input logic [31:0] den);
    if (den == 32'd0) begin
      return 32'hFFFF_FFFF;
    end
    return num / den;
  endfunction

  // Expected word for one requested rate under the given settings.
  // Every intermediate value is 32 bits wide, so sums and shifts wrap.
  function automatic baud_word_t predict_baud_word(input logic [31:0] rate_in,
                                                   input logic [31:0] clock_in,
                                                   input logic        dbl);
    logic [31:0] upper, lower, rate, clkv, limit, ratio, num, quot;
    int e;
    int sh;
    baud_word_t w;
    w = '0;
    clkv = clock_in;
    upper = clkv / 32'd8;
    lower = clkv / MIN_RATE_DIV;
    if (!dbl) begin
      upper = upper >> 1;
      lower = lower >> 1;
    end
    if (rate_in == 32'd0 || rate_in > upper || rate_in < lower) begin
      return w;
    end
    rate = rate_in;
    if (!dbl) begin
      rate = rate << 1;
    end

    // Find the lowest exponent whose limit exceeds the clock-to-rate ratio.
    limit = {{(32-ufbd_pkg::LIMIT_W){1'b0}}, ufbd_pkg::LIMIT_START};
    ratio = divide_or_ones(clkv, rate);
    e = -7;
    while (e < 7 && ratio >= limit) begin
      limit = limit << 1;
      if (e < -3) begin
        limit[0] = 1'b1;
      end
      e = e + 1;
    end

    if (e < 0) begin
      clkv = clkv - (rate << 3);
      if (e <= -3) begin
        sh = -e - 3;
        num = (clkv << sh) + (rate >> 1);
        quot = divide_or_ones(num, rate);
      end else begin
        sh = e + 3;
        rate = rate << sh;
        num = clkv + (rate >> 1);
        quot = divide_or_ones(num, rate);
      end
    end else begin
      sh = e + 3;
      rate = rate << sh;
      num = clkv + (rate >> 1);
      quot = divide_or_ones(num, rate) - 32'd1;
    end
    w.accepted = 1'b1;
    w.divisor = quot[ufbd_pkg::DIV_W-1:0];
    w.scale_exp = e[ufbd_pkg::EXP_W-1:0];
    return w;
  endfunction

  // Random rate: mostly inside the legal range with a wide spread of
  // magnitudes, some right at the bounds, and the rest unconstrained.
  function automatic logic [31:0] pick_rate();
    logic [31:0] upper, lower, raw;
    int unsigned pick;
    upper = clock_hz_q / 32'd8;
    lower = clock_hz_q / MIN_RATE_DIV;
    if (!double_speed_q) begin
      upper = upper >> 1;
      lower = lower >> 1;
    end
    if (lower == 32'd0) begin
      lower = 32'd1;
    end
    raw = $urandom >> $urandom_range(0, 31);
    pick = $urandom_range(0, 99);
    if (pick < 12 || upper < lower) begin
      return (pick < 6) ? $urandom : raw;
    end else if (pick < 18) begin
      case ($urandom_range(0, 4))
        0: return lower;
        1: return lower - 32'd1;
        2: return upper;
        3: return upper + 32'd1;
        default: return 32'd0;
      endcase
    end
    return lower + (raw % (upper - lower + 32'd1));
  endfunction

  // Offer one rate word, with a random gap first, and record its expectation.
  task automatic send_rate(input logic [31:0] rate);
    @(negedge clk);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = rate;
    do begin
      @(posedge clk);
    end while (!in_tready);
    pending_baud_words.push_back(predict_baud_word(rate, clock_hz_q, double_speed_q));
  endtask

  // Stop offering and wait until every expected word has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_baud_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_addr = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    if (idx == ufbd_pkg::REG_CLOCK_HZ) begin
      clock_hz_q = value;
    end else begin
      double_speed_q = value[0];
    end
  endtask

  task automatic apply_settings(input logic [31:0] clock_val, input logic dbl);
    wait_drained();
    write_reg(ufbd_pkg::REG_CLOCK_HZ, clock_val);
    write_reg(ufbd_pkg::REG_DOUBLE_SPEED, {31'd0, dbl});
    settings_used++;
  endtask

  // Bounds and the zero rate at the reset settings (32 MHz, divide by 16).
  task automatic test_reset_bounds();
    send_rate(32'd0);
    send_rate(32'd1);
    send_rate(32'hFFFF_FFFF);
    send_rate(32'd2000000);
    send_rate(32'd2000001);
    send_rate(32'd3);
    send_rate(32'd2);
  endtask

  // Bounds in double-speed mode.
  task automatic test_double_speed_bounds();
    apply_settings(32'd32000000, 1'b1);
    send_rate(32'd4000000);
    send_rate(32'd4000001);
    send_rate(32'd7);
    send_rate(32'd6);
  endtask

  // Rates spaced by shifts of the clock walk the exponent from its lowest to its highest.
  task automatic test_exponent_sweep();
    send_rate(32'd32000000 >> 3);
    send_rate(32'd32000000 >> 6);
    send_rate(32'd32000000 >> 9);
    send_rate(32'd32000000 >> 11);
    send_rate(32'd32000000 >> 13);
    send_rate(32'd32000000 >> 15);
    send_rate(32'd32000000 >> 18);
    send_rate(32'd32000000 >> 22);
  endtask

  // Largest clock, where the numerator wraps, and a clock too slow for any rate.
  task automatic test_extreme_clocks();
    apply_settings(32'hFFFF_FFFF, 1'b0);
    send_rate(32'h0FFF_FFFF);
    send_rate(32'd511);
    send_rate(32'd510);
    apply_settings(32'd1, 1'b1);
    send_rate(32'd1);
  endtask

  // Random rates over a series of settings, one of them with no idling.
  task automatic test_random_settings();
    logic [31:0] clock_val;
    logic dbl;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: clock_val = 32'd32000000;
        1: clock_val = 32'd14745600;
        2: clock_val = 32'hFFFF_FFFF;
        3: clock_val = 32'd1;
        4: clock_val = 32'd1000;
        5: clock_val = 32'd2000000;
        6: clock_val = 32'hFFFF_FFFF;
        default: clock_val = $urandom;
      endcase
      if (clock_val == 32'd0) begin
        clock_val = 32'd1;
      end
      dbl = phase[0];
      apply_settings(clock_val, dbl);
      no_idle = (phase == 5);
      repeat ((phase == 3) ? 60 : 180) send_rate(pick_rate());
    end
    no_idle = 1'b0;
  endtask

  // The receiver holds off while rates keep coming, so the input backs up.
  task automatic test_output_stall();
    apply_settings(32'd32000000, 1'b0);
    @(posedge clk);
    hold_req = 1'b1;
    repeat (12) send_rate(pick_rate());
  endtask

  // Receiver: random stalls, a no-idle stretch, and the long hold-off on request.
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Compare each delivered word with the oldest expectation.
  always @(posedge clk) begin
    baud_word_t want;
    baud_word_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[16:0];
      if (pending_baud_words.size() == 0) begin
        $error("Unexpected result word %h with nothing pending", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_baud_words.pop_front();
        words_checked++;
        if (want.accepted) begin
          words_accepted++;
          exps_seen[$unsigned(want.scale_exp + 4'sd7)] = 1'b1;
        end
        if (got.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
          mismatch_count++;
        end
        if (got.divisor !== want.divisor) begin
          $error("divisor: expected %0d, got %0d", want.divisor, got.divisor);
          mismatch_count++;
        end
        if (got.scale_exp !== want.scale_exp) begin
          $error("scale_exp: expected %0d, got %0d", want.scale_exp, got.scale_exp);
          mismatch_count++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_bounds();
    test_double_speed_bounds();
    test_exponent_sweep();
    test_extreme_clocks();
    test_random_settings();
    test_output_stall();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_baud_words.size() != 0) begin
      $error("%0d expected words never arrived", pending_baud_words.size());
      mismatch_count++;
    end

    $display("Checked %0d rate words (%0d accepted, %0d rejected) over %0d settings.",
             words_checked, words_accepted, words_checked - words_accepted, settings_used);
    $display("Scale exponents reached, -7 in bit 0: %b", exps_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
